[rtl/rae_pkg.sv]
// Shared types and constants of the rotation angle estimator.
package rae_pkg;

	localparam int unsigned TimeW     = 32;
	localparam int unsigned DistW     = 16;
	localparam int unsigned AngleW    = 18;
	localparam int unsigned OffsetW   = 16;
	localparam int unsigned LockoutW  = 10;
	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned QuotW     = 18;
	localparam int unsigned StepCntW  = 5;

	localparam logic [AngleW-1:0]   AngleMax      = {AngleW{1'b1}};
	localparam logic [LockoutW-1:0] LockoutReset  = 10'd30;
	localparam logic [OffsetW-1:0]  OffsetReset   = 16'd12379;
	localparam logic [StepCntW-1:0] LastStep      = 5'(QuotW - 1);

	typedef enum logic {
		REG_LOCKOUT_MS   = 1'b0,
		REG_ANGLE_OFFSET = 1'b1
	} reg_index_t;

	typedef enum logic {
		MODE_HALL   = 1'b0,
		MODE_SAMPLE = 1'b1
	} item_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_PUSH = 3'b100
	} rae_state_t;

endpackage

[rtl/rae_sample_if.sv]
// Input channel: hall edges and range samples.
interface rae_sample_if;
	import rae_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [TimeW-1:0]    now_ms;
	logic [DistW-1:0]    distance_in;

	modport source (output valid, mode, now_ms, distance_in, input ready);
	modport sink   (input valid, mode, now_ms, distance_in, output ready);
endinterface

[rtl/rae_result_if.sv]
// Output channel: angle estimates with their range readings.
interface rae_result_if;
	import rae_pkg::*;

	logic                valid;
	logic                ready;
	logic [AngleW-1:0]   angle;
	logic [DistW-1:0]    distance_out;
	logic                bias_correct;
	logic                period_invalid;

	modport source (output valid, angle, distance_out, bias_correct, period_invalid,
		input ready);
	modport sink   (input valid, angle, distance_out, bias_correct, period_invalid,
		output ready);
endinterface

[rtl/rotation_angle_estimator_unit.sv]
// Rotation angle estimator: top level with an iterative restoring divider.
//
// Usage: items arrive on the sample channel (valid/ready). A hall edge item
// (mode 0) with the edge lock clear updates the revolution period and sets
// the lock when transferred; it produces no result. A range sample (mode 1)
// produces one result on the result channel: angle = elapsed * 65536 /
// period + offset, saturated to 18 bits, plus distance, bias-correction
// flag and a flag for a zero period. Registers lockout_ms (index 0) and
// angle_offset (index 1) are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle (not enforced).
// Timing: a sample runs one quotient bit per cycle through a single 33-bit
// subtractor in ST_DIV; ST_PUSH then loads the output register once it is
// free and returns to ST_IDLE, where the next item is taken. A zero period
// or an angle known to saturate skips the divider and goes to ST_PUSH.
// The output register lets a new item start while a result waits; a finished
// quotient holds until the receiver takes the previous result.
// Reset (arst_n low) clears state, counters and lock and restores the
// register defaults; no result is pending afterwards.
module rotation_angle_estimator_unit #(
	parameter int unsigned CAL_PERIOD = 200
) (
	input  logic                     clk,
	input  logic                     arst_n,
	rae_sample_if.sink               sample,
	rae_result_if.source             result,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [rae_pkg::CfgDataW-1:0] cfg_data
);
	import rae_pkg::*;

	localparam int unsigned CntW = (CAL_PERIOD > 1) ? $clog2(CAL_PERIOD) : 1;
	localparam logic [CntW-1:0] CntLast = CntW'(CAL_PERIOD - 1);

	rae_state_t              state_q;
	logic [LockoutW-1:0]     lockout_q;
	logic [OffsetW-1:0]      offset_q;
	logic [TimeW-1:0]        last_edge_q;
	logic [TimeW-1:0]        period_q;
	logic                    locked_q;
	logic [CntW-1:0]         sample_cnt_q;

	logic [TimeW-1:0]        rem_q;
	logic [1:0]              low_bits_q;
	logic [QuotW-1:0]        quot_q;
	logic [StepCntW-1:0]     step_q;
	logic                    sat_q;
	logic                    invalid_q;
	logic                    bias_q;
	logic [DistW-1:0]        dist_q;

	logic                    out_valid_q;
	logic [AngleW-1:0]       out_angle_q;
	logic [DistW-1:0]        out_dist_q;
	logic                    out_bias_q;
	logic                    out_invalid_q;

	logic                    in_xfer;
	logic [TimeW-1:0]        elapsed;
	logic                    overflow;
	logic [TimeW:0]          trial;
	logic [TimeW:0]          diff;
	logic                    fits;
	logic [AngleW:0]         sum;
	logic [AngleW-1:0]       angle_final;
	logic                    out_free;

	assign sample.ready = (state_q == ST_IDLE);
	assign in_xfer      = sample.valid && sample.ready;
	assign elapsed      = sample.now_ms - last_edge_q;
	// quotient reaches 2^18 exactly when elapsed >= 4 * period
	assign overflow     = {2'b00, elapsed} >= {period_q, 2'b00};

	// shared subtractor: one quotient bit per step
	assign trial = {rem_q, low_bits_q[1]};
	assign diff  = trial - {1'b0, period_q};
	assign fits  = !diff[TimeW];

	assign sum         = {1'b0, quot_q} + {{(AngleW + 1 - OffsetW){1'b0}}, offset_q};
	assign angle_final = (sat_q || invalid_q || sum[AngleW]) ? AngleMax : sum[AngleW-1:0];
	assign out_free    = !out_valid_q || result.ready;

	assign result.valid          = out_valid_q;
	assign result.angle          = out_angle_q;
	assign result.distance_out   = out_dist_q;
	assign result.bias_correct   = out_bias_q;
	assign result.period_invalid = out_invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LockoutReset;
			offset_q  <= OffsetReset;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_LOCKOUT_MS:   lockout_q <= cfg_data[LockoutW-1:0];
				REG_ANGLE_OFFSET: offset_q  <= cfg_data[OffsetW-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_edge_q  <= '0;
			period_q     <= '0;
			locked_q     <= 1'b0;
			sample_cnt_q <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_PUSH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (item_mode_t'(sample.mode) == MODE_HALL) begin
							if (!locked_q) begin
								locked_q    <= 1'b1;
								period_q    <= elapsed;
								last_edge_q <= sample.now_ms;
							end
						end else begin
							sample_cnt_q <= (sample_cnt_q == CntLast) ? '0 : sample_cnt_q + 1'b1;
							if (elapsed >= {{(TimeW - LockoutW){1'b0}}, lockout_q}) begin
								locked_q <= 1'b0;
							end
							step_q  <= '0;
							// skip the divider when the result is already known
							state_q <= (period_q == '0 || overflow) ? ST_PUSH : ST_DIV;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LastStep) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q      <= {2'b00, elapsed[TimeW-1:2]};
				low_bits_q <= elapsed[1:0];
				quot_q     <= '0;
				sat_q      <= overflow;
				invalid_q  <= (period_q == '0);
				bias_q     <= (sample_cnt_q == '0);
				dist_q     <= sample.distance_in;
			end
			ST_DIV: begin
				rem_q      <= fits ? diff[TimeW-1:0] : trial[TimeW-1:0];
				low_bits_q <= {low_bits_q[0], 1'b0};
				quot_q     <= {quot_q[QuotW-2:0], fits};
			end
			ST_PUSH: begin
				if (out_free) begin
					out_angle_q   <= angle_final;
					out_dist_q    <= dist_q;
					out_bias_q    <= bias_q;
					out_invalid_q <= invalid_q;
				end
			end
			default: ;
		endcase
	end

endmodule
